[hdl/edes_pkg.sv]
// Shared constants and types of the earliest-deadline event scheduler.
package edes_pkg;

	localparam int NUM_SLOTS = 16;
	localparam int SLOT_W    = $clog2(NUM_SLOTS);
	localparam int PICK_W    = 5;
	localparam int COUNT_W   = 5;
	localparam int TIME_W    = 32;
	localparam int SPAN_W    = 31;
	localparam int FUNC_W    = 2;
	localparam int CFG_IDX_W = 1;

	localparam logic [PICK_W-1:0]  NO_SLOT   = '1;
	localparam logic [TIME_W-1:0]  ALL_ONES  = '1;
	localparam logic [COUNT_W-1:0] MAX_COUNT = COUNT_W'(NUM_SLOTS);
	localparam logic [SPAN_W-1:0]  IDLE_RST  = SPAN_W'(200000000);

	localparam logic [FUNC_W-1:0] FUNC_REQ = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_ADV = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_QRY = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_SLOTS = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_IDLE  = 1'd1;

	localparam logic KIND_FIRE   = 1'b0;
	localparam logic KIND_STATUS = 1'b1;

	// broadcast from the sequencer to every cell
	typedef struct packed {
		logic               en;
		logic               fire_pass;
		logic               fire_arm;
		logic [COUNT_W-1:0] count;
		logic [TIME_W-1:0]  now;
		logic [TIME_W-1:0]  from;
		logic [SPAN_W-1:0]  span;
		logic               wr_en;
		logic [SLOT_W-1:0]  wr_slot;
		logic               wr_cancel;
		logic [TIME_W-1:0]  wr_start;
		logic [TIME_W-1:0]  wr_end;
	} edes_ctl_t;

	typedef struct packed {
		logic              vld;
		logic [SLOT_W-1:0] slot;
		logic [TIME_W-1:0] remain;
		logic [SPAN_W-1:0] jitter;
	} edes_fire_t;

	typedef struct packed {
		logic              armed;
		logic [TIME_W-1:0] dead;
	} edes_view_t;

endpackage

[hdl/edes_cell.sv]
// One event slot of the scheduler chain with its stage of the nearest-deadline wave.
module edes_cell (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [edes_pkg::SLOT_W-1:0] idx,
	input  edes_pkg::edes_ctl_t        ctl,
	input  logic                       tok_in,
	input  logic [edes_pkg::TIME_W-1:0] best_in,
	input  logic [edes_pkg::PICK_W-1:0] pick_in,
	output logic                       tok_out,
	output logic [edes_pkg::TIME_W-1:0] best_out,
	output logic [edes_pkg::PICK_W-1:0] pick_out,
	output edes_pkg::edes_view_t       view,
	output edes_pkg::edes_fire_t       fire
);
	import edes_pkg::*;

	logic [TIME_W-1:0] start_q;
	logic [TIME_W-1:0] end_q;
	logic              armed_q;
	logic              active;
	logic              due;
	logic              take;
	logic [TIME_W-1:0] left;
	logic [TIME_W-1:0] late;

	always_comb begin
		active = {1'b0, idx} < ctl.count;
		// deadline inside the window just advanced over
		due = active && ctl.fire_arm && armed_q &&
		      ((end_q - ctl.from) <= {1'b0, ctl.span});
		// rank on the state as it stands once this item's firing is done
		left = (armed_q && !due) ? (end_q - ctl.now) : ALL_ONES;
		take = active && (left < best_in);
		late = ctl.now - end_q;
		fire.vld    = tok_in && ctl.en && ctl.fire_pass && due;
		fire.slot   = idx;
		fire.remain = end_q - start_q;
		fire.jitter = late[SPAN_W-1:0];
		view.armed  = armed_q;
		view.dead   = end_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q <= 1'b0;
			tok_out <= 1'b0;
		end else begin
			if (ctl.wr_en && ctl.wr_slot == idx) begin
				armed_q <= !ctl.wr_cancel;
			end else if (fire.vld) begin
				armed_q <= 1'b0;
			end
			if (ctl.en) begin
				tok_out <= tok_in;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.wr_en && ctl.wr_slot == idx) begin
			start_q <= ctl.wr_start;
			if (!ctl.wr_cancel) begin
				end_q <= ctl.wr_end;
			end
		end else if (fire.vld) begin
			start_q <= ctl.now;
		end
		if (ctl.en) begin
			best_out <= take ? left : best_in;
			pick_out <= take ? {1'b0, idx} : pick_in;
		end
	end

endmodule

[hdl/earliest_deadline_event_scheduler.sv]
// Earliest-deadline event scheduler: sequencer, result register and the chain of slot cells.
//
// Requests come in on req_valid/req_stall, results leave on res_valid/res_stall; a transfer
// happens at a clock edge where valid is high and stall is low. Configuration is written on
// cfg_we with cfg_index and cfg_data; the user must write it only while the block is idle,
// as the block itself does not enforce this. One item is taken at a time. A query, an
// unused function code and an advance that leaves the distance non-negative go straight to
// the status step, which registers their status result. A request, or an advance whose
// distance goes negative, sends a token down the sixteen-cell chain, one cell per cycle,
// to find the nearest deadline. When events fire, a second pass down the chain hands out
// one fire result per firing cell in slot order, then the status result (last = 1).
// A new item is taken as soon as the sequencer is back to idle, even while the last result
// still waits in the output register.
// A waiting result is held while res_stall is high, and the firing pass halts in place.
// Reset disarms every slot, clears time and distance and sets no nearest slot; the
// registers return to slot count zero and the default idle period.
module earliest_deadline_event_scheduler (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [edes_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [edes_pkg::SPAN_W-1:0]    cfg_data,
	input  logic                          req_valid,
	output logic                          req_stall,
	input  logic [edes_pkg::FUNC_W-1:0]    func,
	input  logic [edes_pkg::SLOT_W-1:0]    slot,
	input  logic                          cancel,
	input  logic [edes_pkg::SPAN_W-1:0]    cycles,
	output logic                          res_valid,
	input  logic                          res_stall,
	output logic                          kind,
	output logic [edes_pkg::SLOT_W-1:0]    fired_slot,
	output logic [edes_pkg::TIME_W-1:0]    remain,
	output logic [edes_pkg::SPAN_W-1:0]    jitter,
	output logic [edes_pkg::TIME_W-1:0]    remaining,
	output logic signed [edes_pkg::TIME_W-1:0] next_distance,
	output logic [edes_pkg::TIME_W-1:0]    now_time,
	output logic                          last
);
	import edes_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FIRE,
		ST_STATUS
	} state_t;

	state_t             state_q;
	logic [TIME_W-1:0]  now_q;
	logic [TIME_W-1:0]  dist_q;
	logic [PICK_W-1:0]  nearest_q;
	logic [COUNT_W-1:0] slots_q;
	logic [SPAN_W-1:0]  idle_q;
	logic [TIME_W-1:0]  from_q;
	logic [SPAN_W-1:0]  span_q;
	logic               fire_q;
	logic               tok_q;
	logic [TIME_W-1:0]  query_q;

	logic               res_valid_q;
	logic               kind_q;
	logic [SLOT_W-1:0]  fired_slot_q;
	logic [TIME_W-1:0]  remain_q;
	logic [SPAN_W-1:0]  jitter_q;
	logic [TIME_W-1:0]  remaining_q;
	logic [TIME_W-1:0]  next_distance_q;
	logic [TIME_W-1:0]  now_time_q;
	logic               last_q;

	edes_ctl_t          ctl;
	logic [COUNT_W-1:0] count;
	logic               out_free;
	logic               accept;
	logic               launch;
	logic [TIME_W-1:0]  wr_end;
	logic [TIME_W-1:0]  dist_adv;
	logic [TIME_W-1:0]  query_val;
	edes_fire_t         fire_any;

	logic                tok  [NUM_SLOTS+1];
	logic [TIME_W-1:0]   best [NUM_SLOTS+1];
	logic [PICK_W-1:0]   pick [NUM_SLOTS+1];
	edes_view_t          view [NUM_SLOTS];
	edes_fire_t          fires[NUM_SLOTS];
	logic [NUM_SLOTS-1:0] fire_vec;
	logic [NUM_SLOTS-1:0] tok_vec;

	always_comb begin
		count    = (slots_q > MAX_COUNT) ? MAX_COUNT : slots_q;
		out_free = !res_valid_q || !res_stall;
		accept   = req_valid && state_q == ST_IDLE;
		wr_end   = now_q + {1'b0, cycles};
		if (wr_end == ALL_ONES) begin
			wr_end = '0;
		end
		dist_adv  = dist_q - {1'b0, cycles};
		query_val = ({1'b0, slot} < count && view[slot].armed) ?
		            (view[slot].dead - now_q) : ALL_ONES;
		// start a wave for a rescan, or for the firing pass once the rescan is in
		launch = (accept && (func == FUNC_REQ || (func == FUNC_ADV && dist_adv[TIME_W-1]))) ||
		         (state_q == ST_SCAN && tok[NUM_SLOTS] && fire_q);

		ctl.en        = (state_q == ST_FIRE) ? out_free : 1'b1;
		ctl.fire_pass = state_q == ST_FIRE;
		ctl.fire_arm  = fire_q;
		ctl.count     = count;
		ctl.now       = now_q;
		ctl.from      = from_q;
		ctl.span      = span_q;
		ctl.wr_en     = accept && func == FUNC_REQ && {1'b0, slot} < count;
		ctl.wr_slot   = slot;
		ctl.wr_cancel = cancel;
		ctl.wr_start  = now_q;
		ctl.wr_end    = wr_end;

		fire_any = '0;
		for (int i = 0; i < NUM_SLOTS; i++) begin
			fire_vec[i] = fires[i].vld;
			tok_vec[i]  = tok[i+1];
			if (fires[i].vld) begin
				fire_any = fire_any | fires[i];
			end
		end
	end

	assign tok[0]  = tok_q;
	assign best[0] = ALL_ONES;
	assign pick[0] = NO_SLOT;

	for (genvar g = 0; g < NUM_SLOTS; g++) begin : g_cell
		edes_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.idx      (SLOT_W'(g)),
			.ctl      (ctl),
			.tok_in   (tok[g]),
			.best_in  (best[g]),
			.pick_in  (pick[g]),
			.tok_out  (tok[g+1]),
			.best_out (best[g+1]),
			.pick_out (pick[g+1]),
			.view     (view[g]),
			.fire     (fires[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			now_q           <= '0;
			dist_q          <= '0;
			nearest_q       <= NO_SLOT;
			slots_q         <= '0;
			idle_q          <= IDLE_RST;
			from_q          <= '0;
			span_q          <= '0;
			fire_q          <= 1'b0;
			tok_q           <= 1'b0;
			query_q         <= '0;
			res_valid_q     <= 1'b0;
			kind_q          <= KIND_STATUS;
			fired_slot_q    <= '0;
			remain_q        <= '0;
			jitter_q        <= '0;
			remaining_q     <= '0;
			next_distance_q <= '0;
			now_time_q      <= '0;
			last_q          <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_SLOTS: slots_q <= cfg_data[COUNT_W-1:0];
					CFG_IDLE:  idle_q  <= cfg_data;
				endcase
			end
			if (launch) begin
				tok_q <= 1'b1;
			end else if (ctl.en) begin
				tok_q <= 1'b0;
			end
			if (fire_any.vld) begin
				res_valid_q     <= 1'b1;
				kind_q          <= KIND_FIRE;
				fired_slot_q    <= fire_any.slot;
				remain_q        <= fire_any.remain;
				jitter_q        <= fire_any.jitter;
				remaining_q     <= '0;
				next_distance_q <= dist_q;
				now_time_q      <= now_q;
				last_q          <= 1'b0;
			end else if (state_q == ST_STATUS && out_free) begin
				res_valid_q     <= 1'b1;
				kind_q          <= KIND_STATUS;
				fired_slot_q    <= '0;
				remain_q        <= '0;
				jitter_q        <= '0;
				remaining_q     <= query_q;
				next_distance_q <= dist_q;
				now_time_q      <= now_q;
				last_q          <= 1'b1;
			end else if (res_valid_q && !res_stall) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (req_valid) begin
						query_q <= (func == FUNC_QRY) ? query_val : '0;
						fire_q  <= func == FUNC_ADV && dist_adv[TIME_W-1] &&
						           nearest_q != NO_SLOT;
						unique case (func)
							FUNC_REQ: begin
								state_q <= ST_SCAN;
							end
							FUNC_ADV: begin
								now_q  <= now_q + {1'b0, cycles};
								dist_q <= dist_adv;
								from_q <= now_q;
								span_q <= cycles;
								if (dist_adv[TIME_W-1]) begin
									state_q <= ST_SCAN;
								end else begin
									state_q <= ST_STATUS;
								end
							end
							FUNC_QRY: begin
								state_q <= ST_STATUS;
							end
							default: state_q <= ST_STATUS;
						endcase
					end
				end
				ST_SCAN: begin
					if (tok[NUM_SLOTS]) begin
						nearest_q <= pick[NUM_SLOTS];
						dist_q    <= (pick[NUM_SLOTS] != NO_SLOT) ? best[NUM_SLOTS] :
						             {1'b0, idle_q};
						if (fire_q) begin
							state_q <= ST_FIRE;
						end else begin
							state_q <= ST_STATUS;
						end
					end
				end
				ST_FIRE: begin
					if (tok[NUM_SLOTS] && ctl.en) begin
						state_q <= ST_STATUS;
					end
				end
				ST_STATUS: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign req_stall     = state_q != ST_IDLE;
	assign res_valid     = res_valid_q;
	assign kind          = kind_q;
	assign fired_slot    = fired_slot_q;
	assign remain        = remain_q;
	assign jitter        = jitter_q;
	assign remaining     = remaining_q;
	assign next_distance = signed'(next_distance_q);
	assign now_time      = now_time_q;
	assign last          = last_q;

	// at most one cell holds the wave token, so at most one fires per cycle
	a_one_token: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({tok_vec, tok_q}))
		else $error("more than one token in the slot chain");

	a_one_fire: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(fire_vec))
		else $error("several cells fired in one cycle");

	a_fire_room: assert property (@(posedge clk) disable iff (!arst_n)
		fire_any.vld |-> (state_q == ST_FIRE && out_free))
		else $error("fire result produced with no room in the output register");

	a_status_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_STATUS && out_free) |=> (state_q == ST_IDLE && res_valid_q && last_q))
		else $error("status result not issued on leaving the status step");

	a_nearest_range: assert property (@(posedge clk) disable iff (!arst_n)
		(nearest_q == NO_SLOT) || (nearest_q < PICK_W'(NUM_SLOTS)))
		else $error("nearest slot outside the table");

endmodule

[tb/sv/edes_sched_tb_pkg.sv]
// Result predictor and checker for the earliest-deadline event scheduler testbench.
package edes_sched_tb_pkg;
	import edes_pkg::*;

	localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

	typedef struct packed {
		logic              kind;
		logic [SLOT_W-1:0] fired_slot;
		logic [TIME_W-1:0] remain;
		logic [SPAN_W-1:0] jitter;
		logic [TIME_W-1:0] remaining;
		logic [TIME_W-1:0] next_distance;
		logic [TIME_W-1:0] now_time;
		logic              last;
	} sched_result_t;

	class schedule_scoreboard;
		logic [TIME_W-1:0]  armed_at [NUM_SLOTS];
		logic [TIME_W-1:0]  deadline [NUM_SLOTS];
		bit                 armed [NUM_SLOTS];
		logic [TIME_W-1:0]  clock_now;
		logic [TIME_W-1:0]  gap_to_next;
		logic [PICK_W-1:0]  nearest;
		logic [COUNT_W-1:0] scan_cfg;
		logic [SPAN_W-1:0]  idle_cfg;

		sched_result_t due_results[$];
		int unsigned mismatches;
		int unsigned fires_seen;
		int unsigned statuses_seen;
		int unsigned func_hits [4];

		function new();
			for (int i = 0; i < NUM_SLOTS; i++) begin
				armed_at[i] = '0;
				deadline[i] = '0;
				armed[i] = 1'b0;
			end
			clock_now = '0;
			gap_to_next = '0;
			nearest = NO_SLOT;
			scan_cfg = '0;
			idle_cfg = IDLE_RST;
			mismatches = 0;
			fires_seen = 0;
			statuses_seen = 0;
			for (int i = 0; i < 4; i++) func_hits[i] = 0;
		endfunction

		function void set_register(logic [CFG_IDX_W-1:0] idx, logic [SPAN_W-1:0] data);
			if (idx == CFG_SLOTS) scan_cfg = data[COUNT_W-1:0];
			else idle_cfg = data;
		endfunction

		function int unsigned active_slots();
			return (scan_cfg > MAX_COUNT) ? NUM_SLOTS : scan_cfg;
		endfunction

		function logic [TIME_W-1:0] left_of(int unsigned i);
			return armed[i] ? deadline[i] - clock_now : ALL_ONES;
		endfunction

		// first lowest time left wins; all ones can never win
		function void find_nearest();
			logic [TIME_W-1:0] best;
			logic [TIME_W-1:0] r;
			logic [PICK_W-1:0] pick;
			best = ALL_ONES;
			pick = NO_SLOT;
			for (int unsigned i = 0; i < active_slots(); i++) begin
				r = left_of(i);
				if (r < best) begin
					best = r;
					pick = PICK_W'(i);
				end
			end
			nearest = pick;
			gap_to_next = (pick != NO_SLOT) ? best : {1'b0, idle_cfg};
		endfunction

		function void take_request(logic [FUNC_W-1:0] f, logic [SLOT_W-1:0] s, logic c,
				logic [SPAN_W-1:0] cycles);
			sched_result_t batch[$];
			sched_result_t r;
			logic [TIME_W-1:0] span;
			logic [TIME_W-1:0] from;
			logic [TIME_W-1:0] stop;
			logic [TIME_W-1:0] answer;
			span = TIME_W'(cycles);
			answer = '0;
			func_hits[f]++;
			case (f)
				FUNC_REQ: begin
					if (s < active_slots()) begin
						armed_at[s] = clock_now;
						if (c) begin
							armed[s] = 1'b0;
						end else begin
							stop = clock_now + span;
							if (stop == ALL_ONES) stop = '0;
							deadline[s] = stop;
							armed[s] = 1'b1;
						end
					end
					find_nearest();
				end
				FUNC_ADV: begin
					clock_now = clock_now + span;
					gap_to_next = gap_to_next - span;
					if (gap_to_next[TIME_W-1]) begin
						from = clock_now - span;
						if (nearest != NO_SLOT) begin
							for (int unsigned i = 0; i < active_slots(); i++) begin
								if (armed[i] && (deadline[i] - from) <= span) begin
									r = '0;
									r.kind = KIND_FIRE;
									r.fired_slot = SLOT_W'(i);
									r.remain = deadline[i] - armed_at[i];
									r.jitter = SPAN_W'(clock_now - deadline[i]);
									batch = {batch, r};
									armed_at[i] = clock_now;
									armed[i] = 1'b0;
								end
							end
						end
						find_nearest();
					end
				end
				FUNC_QRY: begin
					answer = (s < active_slots()) ? left_of(s) : ALL_ONES;
				end
				default: ;
			endcase
			r = '0;
			r.kind = KIND_STATUS;
			r.remaining = answer;
			r.last = 1'b1;
			batch = {batch, r};
			foreach (batch[j]) begin
				batch[j].next_distance = gap_to_next;
				batch[j].now_time = clock_now;
				due_results = {due_results, batch[j]};
			end
		endfunction

		function string describe(sched_result_t r);
			return $sformatf({"kind=%0d slot=%0d remain=%h jitter=%h remaining=%h",
				" distance=%h now=%h last=%0d"}, r.kind, r.fired_slot, r.remain, r.jitter,
				r.remaining, r.next_distance, r.now_time, r.last);
		endfunction

		function void report(string msg);
			mismatches++;
			if (mismatches <= 10) $display("%s", msg);
		endfunction

		function void check_result(sched_result_t got);
			sched_result_t want;
			string diff;
			if (got.kind == KIND_FIRE) fires_seen++;
			else statuses_seen++;
			if (due_results.size() == 0) begin
				report({"result with nothing outstanding: ", describe(got)});
				return;
			end
			want = due_results.pop_front();
			diff = "";
			if (got.kind !== want.kind) diff = {diff, " kind"};
			if (got.fired_slot !== want.fired_slot) diff = {diff, " fired_slot"};
			if (got.remain !== want.remain) diff = {diff, " remain"};
			if (got.jitter !== want.jitter) diff = {diff, " jitter"};
			if (got.remaining !== want.remaining) diff = {diff, " remaining"};
			if (got.next_distance !== want.next_distance) diff = {diff, " next_distance"};
			if (got.now_time !== want.now_time) diff = {diff, " now_time"};
			if (got.last !== want.last) diff = {diff, " last"};
			if (diff != "")
				report($sformatf("result mismatch in%s\n  expected %s\n  actual   %s", diff,
					describe(want), describe(got)));
		endfunction

		function int unsigned pending();
			return due_results.size();
		endfunction
	endclass

endpackage

[tb/sv/earliest_deadline_event_scheduler_tb.sv]
// Self-checking testbench of the earliest-deadline event scheduler.
module earliest_deadline_event_scheduler_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import edes_pkg::*;
	import edes_sched_tb_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 600000;
	localparam int unsigned LONG_HOLD   = 400;
	localparam int unsigned SETTLE      = 48;

	logic                       clk;
	logic                       arst_n;
	logic                       cfg_we;
	logic [CFG_IDX_W-1:0]       cfg_index;
	logic [SPAN_W-1:0]          cfg_data;
	logic                       req_valid;
	logic                       req_stall;
	logic [FUNC_W-1:0]          func;
	logic [SLOT_W-1:0]          slot;
	logic                       cancel;
	logic [SPAN_W-1:0]          cycles;
	logic                       res_valid;
	logic                       res_stall;
	logic                       kind;
	logic [SLOT_W-1:0]          fired_slot;
	logic [TIME_W-1:0]          remain;
	logic [SPAN_W-1:0]          jitter;
	logic [TIME_W-1:0]          remaining;
	logic signed [TIME_W-1:0]   next_distance;
	logic [TIME_W-1:0]          now_time;
	logic                       last;

	schedule_scoreboard board;
	bit          eager_send;
	bit          hold_results;
	int unsigned scan_setting;
	int unsigned settings_used;
	int unsigned cycle_count = 0;

	earliest_deadline_event_scheduler dut (.*);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycle_count,
				board.pending());
			$display("[earliest_deadline_event_scheduler] ERROR");
			$finish;
		end
	end

	always @(posedge clk) begin
		sched_result_t seen;
		if (arst_n && res_valid === 1'b1 && res_stall === 1'b0) begin
			seen.kind = kind;
			seen.fired_slot = fired_slot;
			seen.remain = remain;
			seen.jitter = jitter;
			seen.remaining = remaining;
			seen.next_distance = next_distance;
			seen.now_time = now_time;
			seen.last = last;
			board.check_result(seen);
		end
	end

	// result side: random stall per result, calm stretches, and one long hold-off on request
	initial begin
		int unsigned wait_cycles;
		int unsigned calm_left;
		res_stall = 1'b0;
		calm_left = 0;
		@(posedge arst_n);
		forever begin
			if (hold_results) begin
				wait_cycles = LONG_HOLD;
				hold_results = 1'b0;
			end else if (calm_left > 0) begin
				wait_cycles = 0;
				calm_left--;
			end else if ($urandom_range(0, 15) == 0) begin
				wait_cycles = 0;
				calm_left = $urandom_range(10, 30);
			end else begin
				wait_cycles = $urandom_range(0, 16);
			end
			@(negedge clk);
			res_stall = (wait_cycles != 0);
			if (wait_cycles > 1) repeat (wait_cycles - 1) @(negedge clk);
			if (wait_cycles != 0) begin
				@(negedge clk);
				res_stall = 1'b0;
			end
			do @(posedge clk); while (res_valid !== 1'b1);
		end
	end

	task automatic offer_request(input logic [FUNC_W-1:0] f, input logic [SLOT_W-1:0] s,
			input logic c, input logic [SPAN_W-1:0] n);
		int unsigned pause;
		pause = eager_send ? 0 : $urandom_range(0, 16);
		@(negedge clk);
		if (pause != 0) begin
			req_valid = 1'b0;
			repeat (pause) @(negedge clk);
		end
		req_valid = 1'b1;
		func = f;
		slot = s;
		cancel = c;
		cycles = n;
		do @(posedge clk); while (req_stall !== 1'b0);
		board.take_request(f, s, c, n);
	endtask

	task automatic settle_results();
		@(negedge clk);
		req_valid = 1'b0;
		while (board.pending() != 0) @(posedge clk);
	endtask

	task automatic apply_setting(input int unsigned count, input logic [SPAN_W-1:0] idle);
		settle_results();
		repeat (SETTLE) @(posedge clk);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = CFG_SLOTS;
		cfg_data = SPAN_W'(count);
		@(negedge clk);
		cfg_index = CFG_IDLE;
		cfg_data = idle;
		@(negedge clk);
		cfg_we = 1'b0;
		board.set_register(CFG_SLOTS, SPAN_W'(count));
		board.set_register(CFG_IDLE, idle);
		scan_setting = count;
		settings_used++;
	endtask

	// mostly short delays so deadlines fall due within a few advances
	function automatic logic [SPAN_W-1:0] draw_span(int unsigned near_max, int unsigned far_max);
		int unsigned r;
		r = $urandom_range(0, 9);
		if (r < 8) return SPAN_W'($urandom_range(0, near_max));
		if (r == 8) return SPAN_W'($urandom_range(0, far_max));
		return SPAN_W'($urandom());
	endfunction

	task automatic random_item();
		int unsigned pick;
		logic [SLOT_W-1:0] s;
		logic c;
		pick = $urandom_range(0, 99);
		if (scan_setting != 0 && $urandom_range(0, 3) != 0)
			s = SLOT_W'($urandom_range(0, scan_setting - 1));
		else
			s = SLOT_W'($urandom_range(0, NUM_SLOTS - 1));
		c = 1'($urandom_range(0, 1));
		if (pick < 48) offer_request(FUNC_REQ, s, pick >= 40, draw_span(400, 20000));
		else if (pick < 80) offer_request(FUNC_ADV, s, c, draw_span(150, 5000));
		else if (pick < 95) offer_request(FUNC_QRY, s, c, SPAN_W'($urandom()));
		else offer_request(FUNC_UNUSED, s, c, SPAN_W'($urandom()));
	endtask

	initial begin
		board = new();
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_SLOTS;
		cfg_data = '0;
		req_valid = 1'b0;
		func = FUNC_REQ;
		slot = '0;
		cancel = 1'b0;
		cycles = '0;
		eager_send = 1'b0;
		hold_results = 1'b0;
		scan_setting = 0;
		settings_used = 0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;

		// no slots scanned after reset: requests drop, queries answer all ones
		offer_request(FUNC_REQ, 4'd3, 1'b0, 31'd10);
		offer_request(FUNC_QRY, 4'd0, 1'b0, 31'd0);
		// distance goes negative with no nearest slot
		offer_request(FUNC_ADV, 4'd0, 1'b0, 31'h7FFF_FFFF);
		offer_request(FUNC_UNUSED, 4'd15, 1'b1, 31'h7FFF_FFFF);

		apply_setting(16, 31'd1);
		offer_request(FUNC_ADV, 4'd0, 1'b0, 31'd1);
		// deadline lands on all ones and is stored as zero
		offer_request(FUNC_REQ, 4'd0, 1'b0, 31'h7FFF_FFFF);
		offer_request(FUNC_QRY, 4'd0, 1'b0, 31'd0);
		offer_request(FUNC_REQ, 4'd15, 1'b0, 31'd0);
		offer_request(FUNC_REQ, 4'd1, 1'b0, 31'd5);
		offer_request(FUNC_REQ, 4'd2, 1'b0, 31'd5);
		offer_request(FUNC_ADV, 4'd7, 1'b1, 31'd0);
		offer_request(FUNC_ADV, 4'd0, 1'b0, 31'd5);
		offer_request(FUNC_REQ, 4'd4, 1'b1, 31'd0);
		offer_request(FUNC_REQ, 4'd0, 1'b1, 31'd0);
		offer_request(FUNC_ADV, 4'd0, 1'b0, 31'd3);
		offer_request(FUNC_REQ, 4'd9, 1'b0, 31'd100);
		offer_request(FUNC_REQ, 4'd8, 1'b0, 31'd1000);

		// hide slots 8 and 9 while time passes the deadline of slot 9
		apply_setting(4, 31'd1);
		offer_request(FUNC_ADV, 4'd0, 1'b0, 31'd101);

		apply_setting(16, 31'h7FFF_FFFF);
		offer_request(FUNC_REQ, 4'd12, 1'b1, 31'd0);
		offer_request(FUNC_QRY, 4'd9, 1'b0, 31'd0);
		offer_request(FUNC_QRY, 4'd3, 1'b0, 31'd0);
		offer_request(FUNC_ADV, 4'd0, 1'b0, 31'd2000);
		offer_request(FUNC_REQ, 4'd15, 1'b0, 31'h7FFF_FFFF);
		offer_request(FUNC_QRY, 4'd15, 1'b0, 31'd0);

		for (int unsigned phase = 0; phase < 5; phase++) begin
			case (phase)
				0: apply_setting(16, 31'd5000);
				1: apply_setting(1, 31'h7FFF_FFFF);
				2: apply_setting($urandom_range(2, 15), SPAN_W'($urandom_range(1, 3000)));
				3: apply_setting(16, 31'd1);
				default: apply_setting($urandom_range(0, 16), IDLE_RST);
			endcase
			for (int unsigned i = 0; i < 49; i++) begin
				eager_send = ((i / 12) % 3 == 1) || (phase == 1 && i >= 20 && i < 32);
				// hold the result side off while requests keep coming
				if (phase == 1 && i == 20) hold_results = 1'b1;
				if (phase == 2 && i == 25) settle_results();
				random_item();
			end
		end

		settle_results();
		repeat (SETTLE) @(posedge clk);
		$display("Covered %0d requests, %0d advances, %0d queries, %0d unused codes over %0d settings.",
			board.func_hits[FUNC_REQ], board.func_hits[FUNC_ADV], board.func_hits[FUNC_QRY],
			board.func_hits[FUNC_UNUSED], settings_used);
		$display("Checked %0d fired events and %0d status results: %0d mismatches.",
			board.fires_seen, board.statuses_seen, board.mismatches);
		if (board.mismatches == 0 && board.pending() == 0)
			$display("[earliest_deadline_event_scheduler] OK");
		else
			$display("[earliest_deadline_event_scheduler] ERROR");
		$finish;
	end

endmodule

[sim.f]
hdl/edes_pkg.sv
hdl/edes_cell.sv
hdl/earliest_deadline_event_scheduler.sv
tb/sv/edes_sched_tb_pkg.sv
tb/sv/earliest_deadline_event_scheduler_tb.sv
